// ----- hdl/lgs_pkg.sv -----
`default_nettype none

package lgs_pkg;

    localparam int SIDE_W     = 6;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 5;
    localparam int COUNT_W    = 4;
    localparam int MIN_SIDE   = 3;
    localparam int SIDE_RESET = 32;
    localparam int QUEUE_DEPTH = 4;

    // one cell to be emitted: masked 3x3 neighborhood, row-major, top-left in bit 0
    typedef struct packed {
        logic [8:0]       win;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_job;

endpackage

`default_nettype wire

// ----- hdl/life_generation_step.sv -----
// Streaming next-generation engine for the Life cellular automaton, rule B3/S23. Cells of
// a square grid of grid_side rows and columns (3 up to GRID_SIZE, values outside clamp) come
// in raster order, one per transaction; the next generation leaves in raster order,
// one row plus one cell behind the input, with neighbor count, position and a flag on
// the frame's final cell. Cells outside the grid are dead. The block takes one cell
// per clock while the output is not stalled: a line buffer RAM with one read and one
// write port per cycle holds the two previous rows. After the last cell of a frame,
// input stalls while the line buffer drains the remaining grid_side + 1 cells. Writing
// grid_side restarts the frame; write it only while the block is idle.
`default_nettype none

module life_generation_step #(
    parameter int GRID_SIZE = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [lgs_pkg::SIDE_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_cell_alive,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_next_alive,
    output logic [lgs_pkg::COUNT_W-1:0]      o_live_neighbors,
    output logic [lgs_pkg::ROW_W-1:0]        o_out_row,
    output logic [lgs_pkg::COL_W-1:0]        o_out_col,
    output logic                             o_frame_last
);
    import lgs_pkg::*;

    logic front_valid;
    logic front_ready;
    t_job front_job;
    logic back_valid;
    logic back_ready;
    t_job back_job;

    lgs_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cell_alive  (i_cell_alive),
        .o_job_valid   (front_valid),
        .i_job_ready   (front_ready),
        .o_job         (front_job)
    );

    lgs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_job   (front_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_job    (back_job)
    );

    lgs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (back_valid),
        .o_job_ready      (back_ready),
        .i_job            (back_job),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_next_alive     (o_next_alive),
        .o_live_neighbors (o_live_neighbors),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_frame_last     (o_frame_last)
    );

endmodule

`default_nettype wire

// ----- hdl/lgs_ram.sv -----
`default_nettype none

module lgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/lgs_front.sv -----
`default_nettype none

module lgs_front #(
    parameter int GRID_SIZE = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [lgs_pkg::SIDE_W-1:0] i_cfg_wr_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_cell_alive,
    output logic                            o_job_valid,
    input  wire logic                       i_job_ready,
    output lgs_pkg::t_job                   o_job
);
    import lgs_pkg::*;

    localparam int CW = $clog2(GRID_SIZE + 1);
    localparam int AW = $clog2(GRID_SIZE);
    localparam logic [CW-1:0] SIDE_AT_RESET =
        CW'((SIDE_RESET > GRID_SIZE) ? GRID_SIZE : SIDE_RESET);

    typedef struct packed {
        logic          is_input;
        logic          alive_bit;
        logic          emit;
        logic [CW-1:0] col;
        logic [CW-1:0] crow;
        logic [CW-1:0] ccol;
    } t_s1;

    logic [CW-1:0] r_side;
    logic [CW-1:0] r_in_row;
    logic [CW-1:0] r_in_col;
    logic          r_flush;
    logic [CW-1:0] r_flush_col;
    logic          r_s1_valid;
    t_s1           r_s1;
    logic [2:0]    r_col_a;
    logic [2:0]    r_col_b;

    logic [CW-1:0] side_clamped;
    logic          s1_fire;
    logic          s1_take;
    logic          issue_in;
    logic          issue_flush;
    logic [CW-1:0] iss_row;
    logic [CW-1:0] iss_col;
    logic          iss_col_zero;
    t_s1           n_s1;
    logic          in_last;
    logic [1:0]    rd_data;
    logic          top_dead;
    logic          bot_dead;
    logic          left_dead;
    logic          right_dead;
    logic [2:0]    row_mask;
    logic [2:0]    new_col;
    logic [2:0]    col_l;
    logic [2:0]    col_m;
    logic [2:0]    col_r;

    always_comb begin
        if (i_cfg_wr_data < SIDE_W'(MIN_SIDE)) begin
            side_clamped = CW'(MIN_SIDE);
        end else if (i_cfg_wr_data > SIDE_W'(GRID_SIZE)) begin
            side_clamped = CW'(GRID_SIZE);
        end else begin
            side_clamped = CW'(i_cfg_wr_data);
        end
    end

    assign s1_fire     = r_s1_valid && (!r_s1.emit || i_job_ready);
    assign s1_take     = !r_s1_valid || s1_fire;
    assign o_in_ready  = !r_flush && s1_take;
    assign issue_in    = i_in_valid && o_in_ready;
    // after the last cell, virtual cells past the bottom row drain the window
    assign issue_flush = r_flush && s1_take;

    assign iss_row      = r_flush ? r_side : r_in_row;
    assign iss_col      = r_flush ? r_flush_col : r_in_col;
    assign iss_col_zero = (iss_col == '0);
    assign in_last      = (r_in_row == r_side - CW'(1)) && (r_in_col == r_side - CW'(1));

    // a cell at column zero closes the previous row's last cell
    always_comb begin
        n_s1.is_input  = !r_flush;
        n_s1.alive_bit = r_flush ? 1'b0 : i_cell_alive;
        n_s1.emit      = (iss_row >= CW'(2)) || ((iss_row == CW'(1)) && !iss_col_zero);
        n_s1.col       = iss_col;
        n_s1.crow      = iss_col_zero ? iss_row - CW'(2) : iss_row - CW'(1);
        n_s1.ccol      = iss_col_zero ? r_side - CW'(1) : iss_col - CW'(1);
    end

    // each entry keeps a column's two most recent rows: bit 0 newest
    lgs_ram #(
        .WIDTH (2),
        .DEPTH (GRID_SIZE)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (s1_fire && r_s1.is_input),
        .i_waddr (r_s1.col[AW-1:0]),
        .i_wdata ({rd_data[0], r_s1.alive_bit}),
        .i_re    (issue_in || issue_flush),
        .i_raddr (iss_col[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign top_dead   = (r_s1.crow == '0);
    assign bot_dead   = (r_s1.crow == r_side - CW'(1));
    assign left_dead  = (r_s1.ccol == '0);
    assign right_dead = (r_s1.ccol == r_side - CW'(1));

    // columns are {bottom, middle, top}
    assign new_col  = {r_s1.alive_bit, rd_data[0], rd_data[1]};
    assign row_mask = {~bot_dead, 1'b1, ~top_dead};
    assign col_l    = r_col_a & row_mask & {3{~left_dead}};
    assign col_m    = r_col_b & row_mask;
    assign col_r    = new_col & row_mask & {3{~right_dead}};

    assign o_job_valid = r_s1_valid && r_s1.emit;
    assign o_job.win   = {col_r[2], col_m[2], col_l[2],
                          col_r[1], col_m[1], col_l[1],
                          col_r[0], col_m[0], col_l[0]};
    assign o_job.row   = ROW_W'(r_s1.crow);
    assign o_job.col   = COL_W'(r_s1.ccol);
    assign o_job.last  = bot_dead && right_dead;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side      <= SIDE_AT_RESET;
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_flush     <= 1'b0;
            r_flush_col <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_side      <= side_clamped;
                r_in_row    <= '0;
                r_in_col    <= '0;
                r_flush     <= 1'b0;
                r_flush_col <= '0;
            end else if (issue_in) begin
                if (in_last) begin
                    r_in_row    <= '0;
                    r_in_col    <= '0;
                    r_flush     <= 1'b1;
                    r_flush_col <= '0;
                end else if (r_in_col == r_side - CW'(1)) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + CW'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end else if (issue_flush) begin
                if (r_flush_col == r_side) begin
                    r_flush <= 1'b0;
                end else begin
                    r_flush_col <= r_flush_col + CW'(1);
                end
            end

            if (issue_in || issue_flush) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_in || issue_flush) begin
            r_s1 <= n_s1;
        end
        if (s1_fire) begin
            r_col_a <= r_col_b;
            r_col_b <= new_col;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lgs_queue.sv -----
`default_nettype none

module lgs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire lgs_pkg::t_job i_push_job,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output lgs_pkg::t_job      o_pop_job
);
    import lgs_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job          r_slots [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != (PW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_slots[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lgs_back.sv -----
`default_nettype none

module lgs_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_job_valid,
    output logic                             o_job_ready,
    input  wire lgs_pkg::t_job               i_job,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_next_alive,
    output logic [lgs_pkg::COUNT_W-1:0]      o_live_neighbors,
    output logic [lgs_pkg::ROW_W-1:0]        o_out_row,
    output logic [lgs_pkg::COL_W-1:0]        o_out_col,
    output logic                             o_frame_last
);
    import lgs_pkg::*;

    logic               r_out_valid;
    logic               r_next_alive;
    logic [COUNT_W-1:0] r_live_neighbors;
    logic [ROW_W-1:0]   r_out_row;
    logic [COL_W-1:0]   r_out_col;
    logic               r_frame_last;

    logic               pop;
    logic [COUNT_W-1:0] count;
    logic               self_alive;

    always_comb begin
        count = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                count = count + COUNT_W'(i_job.win[i]);
            end
        end
    end

    assign self_alive  = i_job.win[4];
    assign o_job_ready = !r_out_valid || i_out_ready;
    assign pop         = i_job_valid && o_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // b3/s23
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_next_alive     <= (count == COUNT_W'(3)) || (self_alive && (count == COUNT_W'(2)));
            r_live_neighbors <= count;
            r_out_row        <= i_job.row;
            r_out_col        <= i_job.col;
            r_frame_last     <= i_job.last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_next_alive     = r_next_alive;
    assign o_live_neighbors = r_live_neighbors;
    assign o_out_row        = r_out_row;
    assign o_out_col        = r_out_col;
    assign o_frame_last     = r_frame_last;

endmodule

`default_nettype wire
